@@ rtl/core/pixel_store_with_line_fill_assert.svh @@
// assertion macros for the pixel store
`ifndef PIXEL_STORE_WITH_LINE_FILL_ASSERT_SVH
`define PIXEL_STORE_WITH_LINE_FILL_ASSERT_SVH

// same-cycle implication, checked outside reset
`define PSF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PSF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/psf_pkg.sv @@
`default_nettype none

package psf_pkg;

  // image geometry
  localparam int MAX_WIDTH   = 64;
  localparam int MAX_HEIGHT  = 64;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COORD_W     = 6;
  localparam int DIM_W       = 7;

  // pixel layout
  localparam int CHAN_W = 16;
  localparam int PIX_W  = 4 * CHAN_W;

  // stream word widths
  localparam int IN_TDATA_W  = 80;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = PIX_W;

  // configuration
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [DIM_W-1:0]     IMAGE_WIDTH_RST  = DIM_W'(64);
  localparam logic [DIM_W-1:0]     IMAGE_HEIGHT_RST = DIM_W'(64);

  // item kind and status codes
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

endpackage

`default_nettype wire

@@ rtl/core/pixel_store_with_line_fill.sv @@
// Row-major store of 4096 RGBA pixels of 64 bits (red in the top 16 bits), pixel (x, y)
// at entry y * width + x with the current width. After reset the block clears the
// whole store, one entry a cycle, and takes no word meanwhile; configuration writes
// are taken at any time. Items are handled one at a time through a single-port
// memory: a pixel read issues the address in idle and registers the data in the
// read state, a single-pixel write or a row, column or full fill writes its pixels
// in the fill state, row by row, and a refused item loads its error word straight
// from idle. The result word sits in an output register, so the next item is taken
// once the block is back in idle and that register is free or being emptied.
`default_nettype none
`include "pixel_store_with_line_fill_assert.svh"

module pixel_store_with_line_fill
  import psf_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration writes
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [DIM_W-1:0]       cfg_wdata_i,
  // input stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // pos_x[5:0], pos_y[11:6], red[27:12], green[43:28], blue[59:44], alpha[75:60], zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // kind[0], every_column[1], every_row[2]
  input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
  // output stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // read_red[15:0], read_green[31:16], read_blue[47:32], read_alpha[63:48]
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // status[0]
  output logic                        m_axis_tuser
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FILL
  } state_e;

  state_e               state_q;
  logic [ADDR_W-1:0]    clr_cnt_q;
  logic [DIM_W-1:0]     width_q, height_q;
  logic [COORD_W-1:0]   x_q, y_q, px_q, py_q;
  logic                 ex_q, ey_q;
  logic [PIX_W-1:0]     colour_q;
  logic                 m_valid_q, m_status_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  // input word fields
  logic                 in_kind, in_ex, in_ey;
  logic [COORD_W-1:0]   in_px, in_py;
  logic [CHAN_W-1:0]    in_red, in_green, in_blue, in_alpha;

  assign in_kind  = s_axis_tuser[0];
  assign in_ex    = s_axis_tuser[1];
  assign in_ey    = s_axis_tuser[2];
  assign in_px    = s_axis_tdata[COORD_W-1:0];
  assign in_py    = s_axis_tdata[2*COORD_W-1:COORD_W];
  assign in_red   = s_axis_tdata[2*COORD_W+CHAN_W-1:2*COORD_W];
  assign in_green = s_axis_tdata[2*COORD_W+2*CHAN_W-1:2*COORD_W+CHAN_W];
  assign in_blue  = s_axis_tdata[2*COORD_W+3*CHAN_W-1:2*COORD_W+2*CHAN_W];
  assign in_alpha = s_axis_tdata[2*COORD_W+4*CHAN_W-1:2*COORD_W+3*CHAN_W];

  // effective image size, clamped to the store
  logic [DIM_W-1:0] w_eff, h_eff;
  assign w_eff = (width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
  assign h_eff = (height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;

  // handshakes
  logic s_fire, out_take, out_free;
  assign out_take      = m_valid_q && m_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // coordinate check
  logic in_bad, req_err, req_read;
  assign in_bad = (w_eff == '0) || (h_eff == '0)
               || (!in_ex && ({1'b0, in_px} >= w_eff))
               || (!in_ey && ({1'b0, in_py} >= h_eff));
  assign req_read = (in_kind == KIND_READ);
  assign req_err  = in_bad || (req_read && (in_ex || in_ey));

  // fill scan bounds
  logic [COORD_W-1:0] x_first, x_last, y_last;
  logic               x_end, y_end;
  assign x_first = ex_q ? '0 : px_q;
  assign x_last  = ex_q ? COORD_W'(w_eff - DIM_W'(1)) : px_q;
  assign y_last  = ey_q ? COORD_W'(h_eff - DIM_W'(1)) : py_q;
  assign x_end   = (x_q == x_last);
  assign y_end   = (y_q == y_last);

  // pixel address: y * width + x
  logic [COORD_W-1:0] ax, ay;
  logic [ADDR_W-1:0]  pix_addr;
  assign ax       = (state_q == ST_IDLE) ? in_px : x_q;
  assign ay       = (state_q == ST_IDLE) ? in_py : y_q;
  assign pix_addr = ADDR_W'(ADDR_W'(ay) * ADDR_W'(w_eff)) + ADDR_W'(ax);

  // memory port control
  logic              ram_en, ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [PIX_W-1:0]  ram_wdata, ram_rdata;

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = pix_addr;
    ram_wdata = colour_q;
    case (state_q)
      ST_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_q;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        ram_en = s_fire && req_read && !req_err;
      end
      ST_FILL: begin
        ram_en = 1'b1;
        ram_we = 1'b1;
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  psf_ram #(
    .DEPTH (STORE_DEPTH),
    .WIDTH (PIX_W)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // sequencer, registers and result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_cnt_q  <= '0;
      width_q    <= IMAGE_WIDTH_RST;
      height_q   <= IMAGE_HEIGHT_RST;
      x_q        <= '0;
      y_q        <= '0;
      px_q       <= '0;
      py_q       <= '0;
      ex_q       <= 1'b0;
      ey_q       <= 1'b0;
      colour_q   <= '0;
      m_valid_q  <= 1'b0;
      m_status_q <= STATUS_OK;
      m_data_q   <= '0;
    end else begin
      // configuration registers
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i;
          REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (out_take) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
          if (clr_cnt_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_fire) begin
            px_q     <= in_px;
            py_q     <= in_py;
            ex_q     <= in_ex;
            ey_q     <= in_ey;
            colour_q <= {in_red, in_green, in_blue, in_alpha};
            x_q      <= in_ex ? '0 : in_px;
            y_q      <= in_ey ? '0 : in_py;
            if (req_err) begin
              m_valid_q  <= 1'b1;
              m_status_q <= STATUS_ERR;
              m_data_q   <= '0;
            end else if (req_read) begin
              state_q <= ST_READ;
            end else begin
              state_q <= ST_FILL;
            end
          end
        end
        ST_READ: begin
          m_valid_q  <= 1'b1;
          m_status_q <= STATUS_OK;
          m_data_q   <= {ram_rdata[CHAN_W-1:0],
                         ram_rdata[2*CHAN_W-1:CHAN_W],
                         ram_rdata[3*CHAN_W-1:2*CHAN_W],
                         ram_rdata[4*CHAN_W-1:3*CHAN_W]};
          state_q    <= ST_IDLE;
        end
        ST_FILL: begin
          if (x_end) begin
            x_q <= x_first;
            if (y_end) begin
              m_valid_q  <= 1'b1;
              m_status_q <= STATUS_OK;
              m_data_q   <= '0;
              state_q    <= ST_IDLE;
            end else begin
              y_q <= y_q + COORD_W'(1);
            end
          end else begin
            x_q <= x_q + COORD_W'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_status_q;

  // result register is never loaded over a word still waiting
  logic out_load;
  assign out_load = (state_q == ST_READ)
                 || ((state_q == ST_FILL) && x_end && y_end)
                 || (s_fire && req_err);

  `PSF_ASSERT_NOW(a_out_no_overwrite, out_load, out_free, "result word overwritten")
  `PSF_ASSERT_NEXT(a_read_issue, s_fire && req_read && !req_err, state_q == ST_READ,
                   "good read did not enter read wait")
  `PSF_ASSERT_NOW(a_clear_zero, state_q == ST_CLEAR, ram_we && (ram_wdata == '0),
                  "clearing pass not writing zero")
  `PSF_ASSERT_NEXT(a_err_no_write, s_fire && req_err, !ram_we,
                   "refused item wrote the store")

endmodule

`default_nettype wire

@@ rtl/core/psf_ram.sv @@
`default_nettype none

module psf_ram #(
  parameter int DEPTH  = 4096,
  parameter int WIDTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] addr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  output logic      [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, registered read data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

`default_nettype wire
